>>> src/mrm_pkg.sv
package mrm_pkg;

    localparam int COEF_W = 16;
    localparam int CTRL_W = 24;
    localparam int ACC_W  = 48;
    localparam int MV_W   = 32;
    localparam int SUM_W  = 32;
    localparam int NUM_W  = 38;
    localparam int CMD_W  = 20;
    localparam int ROW_W  = 3 * COEF_W;
    localparam int CFG_W  = 4;
    localparam int SLOT_REACH = 8;

    localparam logic signed [MV_W-1:0]   Q_ONE   = MV_W'(16384);
    localparam logic signed [COEF_W-1:0] THR_MIN = COEF_W'(163);
    localparam logic signed [MV_W-1:0]   CMD_MAX = MV_W'(524287);
    localparam logic signed [MV_W-1:0]   CMD_MIN = -MV_W'(524288);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MIX  = 1'b1;

    localparam logic [0:0] CFG_MOTOR_COUNT = 1'b0;
    localparam logic [0:0] CFG_DESAT       = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [2:0]               motor_slot;
        logic signed [COEF_W-1:0] roll_value;
        logic signed [COEF_W-1:0] pitch_value;
        logic signed [COEF_W-1:0] yaw_value;
        logic signed [COEF_W-1:0] throttle_value;
    } t_mix_in;

    typedef struct packed {
        logic [2:0]              motor_index;
        logic signed [CMD_W-1:0] motor_command;
        logic                    last_motor;
    } t_mix_out;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [NUM_W-1:0] num;
        logic [SUM_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic signed [MV_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_RD,
        ST_MIX_MAC,
        ST_MIX_WR,
        ST_SH_RD,
        ST_SH_WR,
        ST_SEL,
        ST_RS_MUL,
        ST_RS_MULN,
        ST_RS_ST,
        ST_RS_WAIT,
        ST_SC_RD,
        ST_SC_ST,
        ST_SC_WAIT,
        ST_EM_RD,
        ST_EM_LD
    } t_state;

    function automatic logic signed [MV_W-1:0] round_q14(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        if (a >= 0) begin
            t = (a + ACC_W'(8192)) >>> 14;
        end else begin
            t = -((-a + ACC_W'(8192)) >>> 14);
        end
        return t[MV_W-1:0];
    endfunction

    function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [MV_W-1:0] v);
        logic signed [MV_W-1:0] t;
        if (v > CMD_MAX) begin
            t = CMD_MAX;
        end else if (v < CMD_MIN) begin
            t = CMD_MIN;
        end else begin
            t = v;
        end
        return t[CMD_W-1:0];
    endfunction

endpackage

>>> src/mrm_ram.sv
module mrm_ram #(
    parameter int W     = 48,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/mrm_divider.sv
module mrm_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrm_pkg::t_div_req i_req,
    output mrm_pkg::t_div_rsp o_rsp
);
    import mrm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_q, n_q;
    logic [SUM_W:0]   r_rem, n_rem;
    logic [SUM_W-1:0] r_den, n_den;
    logic             r_neg, n_neg;
    logic [SUM_W:0]   rem_sh, diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        rem_sh = {r_rem[SUM_W-1:0], r_q[NUM_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_q    = i_req.num + NUM_W'(i_req.den >> 1);
            n_rem  = '0;
            n_den  = i_req.den;
            n_neg  = i_req.neg;
        end else if (r_busy) begin
            if (!diff[SUM_W]) begin
                n_rem = diff;
                n_q   = {r_q[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_q   = {r_q[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? -MV_W'(r_q) : MV_W'(r_q);
endmodule

>>> src/multirotor_motor_mixer.sv
// Motor mixer: a load item stores one motor's roll, pitch and yaw coefficients in a
// coefficient memory. A mix item makes one Q1.14 dot product per motor on a single
// multiplier, reading the coefficients and taking three multiply-accumulate steps
// before writing the result to a motor value memory, then emits one command per
// motor, each when the output side is ready. With desaturation on, a shift pass
// follows; rescaling adds three runs of the 38-step serial divider plus a second
// mix pass, and scaling by the maximum adds one divider run per motor. The divider
// runs set the worst case.
module multirotor_motor_mixer #(
    parameter int MAX_MOTORS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mrm_pkg::t_mix_in i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output mrm_pkg::t_mix_out o_out_data,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [mrm_pkg::CFG_W-1:0] i_cfg_data
);
    import mrm_pkg::*;

    localparam int AW  = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int LIM = (MAX_MOTORS < SLOT_REACH) ? MAX_MOTORS : SLOT_REACH;

    t_state r_state, n_state;
    logic [3:0] r_k, n_k;
    logic [1:0] r_t, n_t;
    logic       r_pass, n_pass;
    logic [3:0] r_n, n_n;
    logic signed [CTRL_W-1:0] r_ctrl [3];
    logic signed [CTRL_W-1:0] n_ctrl [3];
    logic signed [COEF_W-1:0] r_thr, n_thr;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [MV_W-1:0]   r_mn, n_mn, r_mx, n_mx;
    logic [SUM_W-1:0]         r_sum, n_sum;
    logic signed [31:0]       r_prod, n_prod;
    logic signed [35:0]       r_num, n_num;
    t_mix_out r_out, n_out;
    logic     r_out_valid, n_out_valid;
    logic [3:0] r_motor_count;
    logic       r_desat;

    logic              coef_we;
    logic [ROW_W-1:0]  coef_rdata;
    logic              coef_re;
    logic              val_we, val_re;
    logic [MV_W-1:0]   val_wdata, val_rdata;
    logic [AW-1:0]     k_addr;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic signed [COEF_W-1:0] coef_sel;
    logic signed [MV_W-1:0]   mv, shifted;
    logic signed [35:0]       num_abs;
    logic [3:0]               n_eff;
    logic                     in_acc;

    assign k_addr  = AW'(r_k);
    assign in_acc  = i_in_valid && o_in_ready;
    assign coef_we = in_acc && (i_in_data.operation == OP_LOAD)
                     && (int'(i_in_data.motor_slot) < MAX_MOTORS);
    assign mv      = $signed(val_rdata);
    assign shifted = (r_mn < 0) ? mv - r_mn : mv;
    assign num_abs = (r_num < 0) ? -r_num : r_num;

    mrm_ram #(.W(ROW_W), .DEPTH(MAX_MOTORS), .AW(AW)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (AW'(i_in_data.motor_slot)),
        .i_wdata ({i_in_data.roll_value, i_in_data.pitch_value, i_in_data.yaw_value}),
        .i_re    (coef_re),
        .i_raddr (k_addr),
        .o_rdata (coef_rdata)
    );

    mrm_ram #(.W(MV_W), .DEPTH(MAX_MOTORS), .AW(AW)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (k_addr),
        .i_wdata (val_wdata),
        .i_re    (val_re),
        .i_raddr (k_addr),
        .o_rdata (val_rdata)
    );

    mrm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_motor_count == 4'd0) begin
            n_eff = 4'd1;
        end else if (int'(r_motor_count) > LIM) begin
            n_eff = 4'(LIM);
        end else begin
            n_eff = r_motor_count;
        end
        case (r_t)
            2'd0:    coef_sel = $signed(coef_rdata[3*COEF_W-1:2*COEF_W]);
            2'd1:    coef_sel = $signed(coef_rdata[2*COEF_W-1:COEF_W]);
            default: coef_sel = $signed(coef_rdata[COEF_W-1:0]);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_t     = r_t;
        n_pass  = r_pass;
        n_n     = r_n;
        n_ctrl  = r_ctrl;
        n_thr   = r_thr;
        n_acc   = r_acc;
        n_mn    = r_mn;
        n_mx    = r_mx;
        n_sum   = r_sum;
        n_prod  = r_prod;
        n_num   = r_num;
        n_out   = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        coef_re   = 1'b0;
        val_we    = 1'b0;
        val_re    = 1'b0;
        val_wdata = '0;
        div_req   = '0;
        o_in_ready = (r_state == ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in_data.operation == OP_MIX) begin
                    n_ctrl[0] = CTRL_W'(i_in_data.roll_value);
                    n_ctrl[1] = CTRL_W'(i_in_data.pitch_value);
                    n_ctrl[2] = CTRL_W'(i_in_data.yaw_value);
                    n_thr     = i_in_data.throttle_value;
                    n_n       = n_eff;
                    n_k       = '0;
                    n_pass    = 1'b0;
                    n_state   = ST_MIX_RD;
                end
            end
            ST_MIX_RD: begin
                coef_re = 1'b1;
                n_acc   = ACC_W'(r_thr) <<< 14;
                n_t     = 2'd0;
                n_state = ST_MIX_MAC;
            end
            ST_MIX_MAC: begin
                n_acc = r_acc + ACC_W'(r_ctrl[r_t]) * ACC_W'(coef_sel);
                if (r_t == 2'd2) begin
                    n_state = ST_MIX_WR;
                end else begin
                    n_t = r_t + 2'd1;
                end
            end
            ST_MIX_WR: begin
                val_we    = 1'b1;
                val_wdata = round_q14(r_acc);
                if (r_k == 4'd0 || round_q14(r_acc) < r_mn) begin
                    n_mn = round_q14(r_acc);
                end
                if (r_k == r_n - 4'd1) begin
                    n_k     = '0;
                    n_state = (r_pass || !r_desat) ? ST_EM_RD : ST_SH_RD;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = ST_MIX_RD;
                end
            end
            ST_SH_RD: begin
                val_re  = 1'b1;
                n_state = ST_SH_WR;
            end
            ST_SH_WR: begin
                val_we    = 1'b1;
                val_wdata = shifted;
                if (r_k == 4'd0) begin
                    n_mx  = shifted;
                    n_sum = SUM_W'(shifted);
                end else begin
                    if (shifted > r_mx) begin
                        n_mx = shifted;
                    end
                    n_sum = r_sum + SUM_W'(shifted);
                end
                if (r_k == r_n - 4'd1) begin
                    n_k     = '0;
                    n_state = ST_SEL;
                end else begin
                    n_k     = r_k + 4'd1;
                    n_state = ST_SH_RD;
                end
            end
            ST_SEL: begin
                if (r_mx > Q_ONE) begin
                    if (r_thr > THR_MIN) begin
                        n_t     = 2'd0;
                        n_state = ST_RS_MUL;
                    end else begin
                        n_state = ST_SC_RD;
                    end
                end else begin
                    n_state = ST_EM_RD;
                end
            end
            ST_RS_MUL: begin
                n_prod  = $signed(r_ctrl[r_t][COEF_W-1:0]) * r_thr;
                n_state = ST_RS_MULN;
            end
            ST_RS_MULN: begin
                n_num   = 36'(r_prod) * $signed({1'b0, r_n});
                n_state = ST_RS_ST;
            end
            ST_RS_ST: begin
                div_req.start = 1'b1;
                div_req.neg   = r_num < 0;
                div_req.num   = NUM_W'(unsigned'(num_abs));
                div_req.den   = r_sum;
                n_state       = ST_RS_WAIT;
            end
            ST_RS_WAIT: begin
                if (div_rsp.done) begin
                    n_ctrl[r_t] = CTRL_W'(div_rsp.quot);
                    if (r_t == 2'd2) begin
                        n_pass  = 1'b1;
                        n_k     = '0;
                        n_state = ST_MIX_RD;
                    end else begin
                        n_t     = r_t + 2'd1;
                        n_state = ST_RS_MUL;
                    end
                end
            end
            ST_SC_RD: begin
                val_re  = 1'b1;
                n_state = ST_SC_ST;
            end
            ST_SC_ST: begin
                div_req.start = 1'b1;
                div_req.neg   = 1'b0;
                div_req.num   = {val_rdata[NUM_W-15:0], 14'b0};
                div_req.den   = SUM_W'(r_mx);
                n_state       = ST_SC_WAIT;
            end
            ST_SC_WAIT: begin
                if (div_rsp.done) begin
                    val_we    = 1'b1;
                    val_wdata = div_rsp.quot;
                    if (r_k == r_n - 4'd1) begin
                        n_k     = '0;
                        n_state = ST_EM_RD;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = ST_SC_RD;
                    end
                end
            end
            ST_EM_RD: begin
                val_re  = 1'b1;
                n_state = ST_EM_LD;
            end
            ST_EM_LD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.motor_index   = r_k[2:0];
                    n_out.motor_command = sat_cmd(mv);
                    n_out.last_motor    = (r_k == r_n - 4'd1);
                    n_out_valid         = 1'b1;
                    if (r_k == r_n - 4'd1) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 4'd1;
                        n_state = ST_EM_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_motor_count <= 4'd4;
            r_desat       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MOTOR_COUNT: r_motor_count <= i_cfg_data[3:0];
                    CFG_DESAT:       r_desat       <= i_cfg_data[0];
                    default:         r_desat       <= r_desat;
                endcase
            end
        end
        r_k    <= n_k;
        r_t    <= n_t;
        r_pass <= n_pass;
        r_n    <= n_n;
        r_ctrl <= n_ctrl;
        r_thr  <= n_thr;
        r_acc  <= n_acc;
        r_mn   <= n_mn;
        r_mx   <= n_mx;
        r_sum  <= n_sum;
        r_prod <= n_prod;
        r_num  <= n_num;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

>>> sim/multirotor_motor_mixer_tb.sv
`timescale 1ns / 100ps

module multirotor_motor_mixer_tb;
    import mrm_pkg::*;

    localparam int SETTLE_CYCLES = 700;
    localparam int STALL_LIMIT   = 5000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              o_in_ready;
    t_mix_in           in_data = '0;
    logic              o_out_valid;
    logic              out_ready = 1'b0;
    t_mix_out          o_out_data;
    logic              cfg_we = 1'b0;
    logic [0:0]        cfg_index = CFG_MOTOR_COUNT;
    logic [CFG_W-1:0]  cfg_data = '0;

    multirotor_motor_mixer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_mix_in   pending_items[$];
    t_mix_out  expected_cmds[$];
    logic signed [15:0] coef_rows[8][3];
    logic [3:0] model_count = 4'd4;
    logic       model_desat = 1'b0;
    int errors = 0;
    int mixes_done = 0;
    int loads_done = 0;
    int cmds_seen = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int idle_cycles = 0;

    function automatic longint round_div(longint num, longint den);
        if (num >= 0) begin
            return (num + den / 2) / den;
        end
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint motor_dot(int k, longint c[4]);
        longint acc;
        acc = c[0] * longint'(coef_rows[k][0]) + c[1] * longint'(coef_rows[k][1])
            + c[2] * longint'(coef_rows[k][2]) + c[3] * 16384;
        return round_div(acc, 16384);
    endfunction

    task automatic predict_mix(t_mix_in it);
        longint ctrl[4];
        longint mv[8];
        longint mn, mx, sum, v;
        int n;
        t_mix_out r;
        if (it.operation == OP_LOAD) begin
            coef_rows[it.motor_slot][0] = it.roll_value;
            coef_rows[it.motor_slot][1] = it.pitch_value;
            coef_rows[it.motor_slot][2] = it.yaw_value;
            loads_done++;
            return;
        end
        mixes_done++;
        ctrl[0] = it.roll_value;
        ctrl[1] = it.pitch_value;
        ctrl[2] = it.yaw_value;
        ctrl[3] = it.throttle_value;
        n = int'(model_count);
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        for (int k = 0; k < n; k++) mv[k] = motor_dot(k, ctrl);
        if (model_desat) begin
            mn = mv[0];
            for (int k = 1; k < n; k++) if (mv[k] < mn) mn = mv[k];
            if (mn < 0) for (int k = 0; k < n; k++) mv[k] -= mn;
            mx = mv[0];
            sum = 0;
            for (int k = 0; k < n; k++) begin
                if (mv[k] > mx) mx = mv[k];
                sum += mv[k];
            end
            if (mx > 16384) begin
                if (ctrl[3] > 163) begin
                    for (int i = 0; i < 3; i++)
                        ctrl[i] = round_div(ctrl[i] * ctrl[3] * n, sum);
                    for (int k = 0; k < n; k++) mv[k] = motor_dot(k, ctrl);
                end else begin
                    for (int k = 0; k < n; k++) mv[k] = round_div(mv[k] * 16384, mx);
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            v = mv[k];
            if (v > 524287) v = 524287;
            if (v < -524288) v = -524288;
            r.motor_index   = 3'(k);
            r.motor_command = CMD_W'(v);
            r.last_motor    = (k == n - 1);
            expected_cmds.push_back(r);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_mix(in_data);
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_data <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    send_gap = $urandom_range(0, 3);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                cmds_seen++;
                if (expected_cmds.size() == 0) begin
                    $error("unexpected command motor_index=%0d motor_command=%0d",
                           o_out_data.motor_index, o_out_data.motor_command);
                    errors++;
                end else begin
                    t_mix_out e;
                    e = expected_cmds.pop_front();
                    if (o_out_data.motor_index !== e.motor_index) begin
                        $error("motor_index expected %0d actual %0d",
                               e.motor_index, o_out_data.motor_index);
                        errors++;
                    end
                    if (o_out_data.motor_command !== e.motor_command) begin
                        $error("motor_command expected %0d actual %0d",
                               e.motor_command, o_out_data.motor_command);
                        errors++;
                    end
                    if (o_out_data.last_motor !== e.last_motor) begin
                        $error("last_motor expected %0d actual %0d",
                               e.last_motor, o_out_data.last_motor);
                        errors++;
                    end
                end
                recv_stall = $urandom_range(0, 3);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL multirotor_motor_mixer");
                $finish;
            end
        end
    end

    function automatic logic signed [15:0] rand_q14();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    function automatic t_mix_in make_item(logic op, logic [2:0] slot, logic signed [15:0] r,
                                          logic signed [15:0] p, logic signed [15:0] y,
                                          logic signed [15:0] t);
        t_mix_in it;
        it.operation = op;
        it.motor_slot = slot;
        it.roll_value = r;
        it.pitch_value = p;
        it.yaw_value = y;
        it.throttle_value = t;
        return it;
    endfunction

    task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MOTOR_COUNT) model_count = val;
        else model_desat = val[0];
        @(posedge i_clk);
    endtask

    task automatic drain_all();
        while (pending_items.size() > 0 || in_valid || expected_cmds.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(int count);
        logic signed [15:0] y;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                y = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'(($urandom_range(0, 2) - 1) * 16384);
                pending_items.push_back(make_item(OP_LOAD, 3'($urandom), rand_q14(),
                                                  rand_q14(), y, 16'($urandom)));
            end else begin
                pending_items.push_back(make_item(OP_MIX, 3'($urandom), rand_q14(),
                                                  rand_q14(), rand_q14(), rand_q14()));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 8; k++) begin
            pending_items.push_back(make_item(OP_LOAD, 3'(k),
                16'((k[0] ? 1 : -1) * 8192), 16'((k[1] ? 1 : -1) * 8192),
                16'((k[2] ? 1 : -1) * 16384), 16'h7fff));
        end
        pending_items.push_back(make_item(OP_MIX, 3'd7, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        pending_items.push_back(make_item(OP_MIX, 3'd0, -16'sh8000, -16'sh8000, -16'sh8000,
                                          -16'sh8000));
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0));
        drain_all();

        write_reg(CFG_MOTOR_COUNT, 4'd8);
        write_reg(CFG_DESAT, 4'd1);
        pending_items.push_back(make_item(OP_LOAD, 3'd7, 16'sh7fff, -16'sh8000, 16'sh7fff, 16'sd0));
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sd8000, 16'sd4000, 16'sd2000, 16'sd163));
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sd8000, 16'sd4000, 16'sd2000, 16'sd164));
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sd8000, 16'sd4000, 16'sd2000, 16'sd12000));
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sd100, -16'sd100, 16'sd0, 16'sd8000));
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sh7fff, -16'sh8000, 16'sh7fff,
                                          16'sh7fff));
        pending_items.push_back(make_item(OP_MIX, 3'd0, -16'sh8000, 16'sh7fff, -16'sh8000,
                                          -16'sh8000));
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sd0, 16'sd0, 16'sd0, -16'sd5000));
        drain_all();

        write_reg(CFG_MOTOR_COUNT, 4'd0);
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sd9000, 16'sd0, 16'sd0, 16'sd100));
        drain_all();
        write_reg(CFG_MOTOR_COUNT, 4'd15);
        pending_items.push_back(make_item(OP_MIX, 3'd0, 16'sd9000, 16'sd9000, 16'sd0, 16'sd100));
        drain_all();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin write_reg(CFG_MOTOR_COUNT, 4'd1); write_reg(CFG_DESAT, 4'd1); end
                1: begin write_reg(CFG_MOTOR_COUNT, 4'd8); write_reg(CFG_DESAT, 4'd0); end
                2: begin write_reg(CFG_MOTOR_COUNT, 4'd15); write_reg(CFG_DESAT, 4'd1); end
                3: begin write_reg(CFG_MOTOR_COUNT, 4'd0); write_reg(CFG_DESAT, 4'd0); end
                default: begin
                    write_reg(CFG_MOTOR_COUNT, 4'($urandom));
                    write_reg(CFG_DESAT, 4'($urandom_range(0, 1)));
                end
            endcase
            queue_random(44);
            drain_all();
        end

        $display("covered %0d loads and %0d mixes, %0d motor commands checked",
                 loads_done, mixes_done, cmds_seen);
        $display("motor counts from out of range low to high, desaturation on and off");
        if (errors == 0 && expected_cmds.size() == 0) begin
            $display("PASS multirotor_motor_mixer");
        end else begin
            if (expected_cmds.size() != 0)
                $error("%0d expected commands never arrived", expected_cmds.size());
            $display("FAIL multirotor_motor_mixer");
        end
        $finish;
    end

endmodule

>>> sim.f
src/mrm_pkg.sv
src/mrm_ram.sv
src/mrm_divider.sv
src/multirotor_motor_mixer.sv
sim/multirotor_motor_mixer_tb.sv
